/* rtl/i2cram_pkg.sv */
`default_nettype none

package i2cram_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd1;

	localparam logic [15:0] QUARTER_PERIOD_RESET = 16'd62;
	localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd57;

	// command codes carried in the kind field
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       scl_in;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_value;
		logic       rejected;
	} rsp_t;

	typedef struct packed {
		logic [15:0] quarter_period_ticks;
		logic [6:0]  device_address;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/i2cram_cfg_regs.sv */
`default_nettype none

module i2cram_cfg_regs (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wr_en,
	input  wire logic [i2cram_pkg::CFG_IDX_W-1:0]     wr_index,
	input  wire logic [i2cram_pkg::CFG_DATA_W-1:0]    wr_data,
	output      i2cram_pkg::cfg_t                     cfg
);
	import i2cram_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quarter_period_ticks <= QUARTER_PERIOD_RESET;
			cfg_q.device_address       <= DEVICE_ADDRESS_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_QUARTER_PERIOD: cfg_q.quarter_period_ticks <= wr_data[15:0];
				CFG_DEVICE_ADDRESS: cfg_q.device_address       <= wr_data[6:0];
				default: ; // unmapped index, write ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/i2cram_engine.sv */
`default_nettype none

module i2cram_engine (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire i2cram_pkg::req_t   req,
	input  wire i2cram_pkg::cfg_t   cfg,
	output      i2cram_pkg::rsp_t   rsp
);
	import i2cram_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_START0, ST_START1, ST_START2,
		ST_BIT0, ST_BIT_HIGH, ST_BIT2,
		ST_STOP0, ST_STOP1, ST_STOP2
	} step_t;

	typedef enum logic [1:0] {EL_START, EL_WBYTE, EL_RBYTE, EL_STOP} el_kind_t;

	function automatic el_kind_t elem_kind(input logic rd, input logic [2:0] bi);
		el_kind_t k;
		k = EL_STOP;
		if (rd) begin
			case (bi)
				3'd0, 3'd3:       k = EL_START;
				3'd1, 3'd2, 3'd4: k = EL_WBYTE;
				3'd5:             k = EL_RBYTE;
				default:          k = EL_STOP;
			endcase
		end else begin
			case (bi)
				3'd0:             k = EL_START;
				3'd1, 3'd2, 3'd3: k = EL_WBYTE;
				default:          k = EL_STOP;
			endcase
		end
		return k;
	endfunction

	function automatic logic [7:0] byte_to_load(input logic [2:0] bi, input logic [6:0] dev,
			input logic [7:0] sreg, input logic [7:0] sdat);
		logic [7:0] b;
		case (bi)
			3'd1:    b = {dev, 1'b0};
			3'd2:    b = sreg;
			3'd3:    b = sdat;
			3'd4:    b = {dev, 1'b1};
			default: b = 8'd0;
		endcase
		return b;
	endfunction

	step_t       step_q;
	logic [15:0] phase_q;
	logic [3:0]  bit_cnt_q;
	logic [7:0]  shift_q;
	logic [2:0]  byte_idx_q;
	logic        is_read_q;
	logic [7:0]  rx_byte_q;
	logic [7:0]  sav_reg_q;
	logic [7:0]  sav_data_q;
	rsp_t        rsp_q;

	step_t       nx_step;
	logic [15:0] nx_phase;
	logic [3:0]  nx_bit_cnt;
	logic [7:0]  nx_shift;
	logic [2:0]  nx_byte_idx;
	logic        nx_is_read;
	logic [7:0]  nx_rx_byte;
	logic [7:0]  nx_sav_reg;
	logic [7:0]  nx_sav_data;
	rsp_t        nx_rsp;

	logic        is_cmd;
	logic        busy;
	logic        hold;
	logic        enter;
	logic        tx_bit;
	logic [1:0]  drives;
	logic [15:0] quarter;
	el_kind_t    cur_el;
	el_kind_t    new_el;

	assign quarter = (cfg.quarter_period_ticks == 16'd0) ? 16'd1 : cfg.quarter_period_ticks;
	assign is_cmd  = (req.kind == KIND_WRITE) || (req.kind == KIND_READ);

	always_comb begin
		nx_step     = step_q;
		nx_phase    = phase_q;
		nx_bit_cnt  = bit_cnt_q;
		nx_shift    = shift_q;
		nx_byte_idx = byte_idx_q;
		nx_is_read  = is_read_q;
		nx_rx_byte  = rx_byte_q;
		nx_sav_reg  = sav_reg_q;
		nx_sav_data = sav_data_q;
		nx_rsp      = '0;
		enter       = 1'b0;
		new_el      = EL_STOP;

		if (is_cmd) begin
			if (step_q != ST_IDLE) begin
				nx_rsp.rejected = 1'b1;
			end else begin
				nx_is_read  = (req.kind == KIND_READ);
				nx_sav_reg  = req.reg_addr;
				nx_sav_data = req.write_data;
				nx_byte_idx = 3'd0;
				nx_bit_cnt  = 4'd0;
				nx_shift    = 8'd0;
				nx_phase    = 16'd0;
				nx_step     = ST_START0;
			end
		end

		busy   = (nx_step != ST_IDLE);
		cur_el = elem_kind(nx_is_read, nx_byte_idx);

		// line levels for this tick, taken before the phase moves on
		tx_bit = (cur_el == EL_WBYTE && nx_bit_cnt < 4'd8) ? nx_shift[7] : 1'b1;
		unique case (nx_step)
			ST_START0:   drives = 2'b11;
			ST_START1:   drives = 2'b10;
			ST_START2:   drives = 2'b00;
			ST_BIT0:     drives = {1'b0, tx_bit};
			ST_BIT_HIGH: drives = {1'b1, tx_bit};
			ST_BIT2:     drives = {1'b0, tx_bit};
			ST_STOP0:    drives = 2'b00;
			ST_STOP1:    drives = 2'b10;
			default:     drives = 2'b11;
		endcase

		// clock stretching: SCL-high count starts only once the line is seen high
		hold = (nx_step == ST_BIT_HIGH) && (nx_phase == 16'd0) && !req.scl_in;

		if (busy && !hold) begin
			if ({1'b0, nx_phase} + 17'd1 >= {1'b0, quarter}) begin
				nx_phase = 16'd0;
				unique case (nx_step)
					ST_START0:   nx_step = ST_START1;
					ST_START1:   nx_step = ST_START2;
					ST_STOP0:    nx_step = ST_STOP1;
					ST_STOP1:    nx_step = ST_STOP2;
					ST_START2: begin
						nx_byte_idx = nx_byte_idx + 3'd1;
						enter       = 1'b1;
					end
					ST_BIT0:     nx_step = ST_BIT_HIGH;
					ST_BIT_HIGH: begin
						if (cur_el == EL_RBYTE && nx_bit_cnt < 4'd8)
							nx_shift = {nx_shift[6:0], req.sda_in};
						nx_step = ST_BIT2;
					end
					ST_BIT2: begin
						if (cur_el == EL_WBYTE && nx_bit_cnt < 4'd8)
							nx_shift = {nx_shift[6:0], 1'b0};
						nx_bit_cnt = nx_bit_cnt + 4'd1;
						if (nx_bit_cnt >= 4'd9) begin
							nx_byte_idx = nx_byte_idx + 3'd1;
							enter       = 1'b1;
						end else begin
							nx_step = ST_BIT0;
						end
					end
					ST_STOP2: begin
						if (nx_is_read)
							nx_rx_byte = nx_shift;
						nx_step         = ST_IDLE;
						nx_rsp.done_res = 1'b1;
					end
					default:     nx_step = ST_IDLE;
				endcase
			end else begin
				nx_phase = nx_phase + 16'd1;
			end
		end

		if (enter) begin
			new_el = elem_kind(nx_is_read, nx_byte_idx);
			case (new_el)
				EL_START: nx_step = ST_START0;
				EL_STOP:  nx_step = ST_STOP0;
				default: begin
					nx_step    = ST_BIT0;
					nx_bit_cnt = 4'd0;
					nx_shift   = byte_to_load(nx_byte_idx, cfg.device_address,
						nx_sav_reg, nx_sav_data);
				end
			endcase
		end

		nx_rsp.scl_drive  = drives[1];
		nx_rsp.sda_drive  = drives[0];
		nx_rsp.busy_res   = busy;
		nx_rsp.read_value = nx_rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= ST_IDLE;
			phase_q    <= 16'd0;
			bit_cnt_q  <= 4'd0;
			shift_q    <= 8'd0;
			byte_idx_q <= 3'd0;
			is_read_q  <= 1'b0;
			rx_byte_q  <= 8'd0;
			sav_reg_q  <= 8'd0;
			sav_data_q <= 8'd0;
			rsp_q      <= '0;
		end else if (advance) begin
			step_q     <= nx_step;
			phase_q    <= nx_phase;
			bit_cnt_q  <= nx_bit_cnt;
			shift_q    <= nx_shift;
			byte_idx_q <= nx_byte_idx;
			is_read_q  <= nx_is_read;
			rx_byte_q  <= nx_rx_byte;
			sav_reg_q  <= nx_sav_reg;
			sav_data_q <= nx_sav_data;
			rsp_q      <= nx_rsp;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

/* rtl/i2c_register_access_master.sv */
// I2C register-access master, one tick of bus timing per request.
// req channel (req_valid / req_stall / req): each request is one tick carrying
// the sampled SCL and SDA levels and optionally a write or read command.
// rsp channel (rsp_valid / rsp_stall / rsp): exactly one response per request,
// in order, with the line drives for that tick, busy, done, rejected and the
// byte of the last finished read.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 sets
// the quarter bus period in ticks, index 1 the seven-bit device address.
// cfg_ready is always high; write only while no transaction is in flight.
// A request waits in the input register until the response register can take
// its result, which then shows as valid on the rsp channel.
// One request per cycle while rsp_stall is low; the sequencer step is a single pass of
// logic between the input register and the response register.
// When rsp_stall is high the response register holds, the input register
// still fills once, then req_stall rises until the response is taken.
// Reset empties both registers, idles the sequencer with both lines released
// and restores the configuration defaults (62 ticks, address 57).
`default_nettype none

module i2c_register_access_master (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output      logic                               req_stall,
	input  wire i2cram_pkg::req_t                   req,
	output      logic                               rsp_valid,
	input  wire logic                               rsp_stall,
	output      i2cram_pkg::rsp_t                   rsp,
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic [i2cram_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [i2cram_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import i2cram_pkg::*;

	logic valid_s1;
	req_t req_s1;
	logic rsp_valid_q;
	logic advance;
	cfg_t cfg;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!req_stall)
				valid_s1 <= req_valid;
			if (advance)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			req_s1 <= req;
	end

	i2cram_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	i2cram_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req_s1),
		.cfg     (cfg),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire

/* bench/tb_i2c_register_access_master.sv */
`default_nettype none

module tb_i2c_register_access_master;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cram_pkg::*;

	// spare command code, behaves as a plain tick
	localparam logic [1:0] KIND_NONE = 2'd3;

	// how the sampled SDA is generated during a bus transfer
	localparam int SDA_LOW    = 0;
	localparam int SDA_HIGH   = 1;
	localparam int SDA_RANDOM = 2;

	typedef enum bit [4:0] {
		SEQ_IDLE,
		SEQ_START_HIGH,
		SEQ_START_SDA_LOW,
		SEQ_START_SCL_LOW,
		SEQ_BIT_LOW,
		SEQ_BIT_HIGH,
		SEQ_BIT_TAIL,
		SEQ_STOP_LOW,
		SEQ_STOP_SCL_HIGH,
		SEQ_STOP_SDA_HIGH
	} seq_e;

	typedef enum bit [1:0] {
		ELEM_START,
		ELEM_SEND,
		ELEM_RECV,
		ELEM_STOP
	} elem_e;

	class i2c_tick_scoreboard;
		bit [15:0] quarter  = QUARTER_PERIOD_RESET;
		bit [6:0]  dev_addr = DEVICE_ADDRESS_RESET;
		seq_e      step     = SEQ_IDLE;
		bit [15:0] phase_cnt;
		bit [3:0]  bit_cnt;
		bit [7:0]  shifter;
		bit [2:0]  byte_idx;
		bit        reading;
		bit [7:0]  last_read;
		bit [7:0]  reg_latched;
		bit [7:0]  data_latched;
		rsp_t      expected_ticks[$];
		int unsigned ticks, writes_done, reads_done, refused, settings, mismatches;

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			settings++;
			if (idx == CFG_QUARTER_PERIOD)
				quarter = value;
			else if (idx == CFG_DEVICE_ADDRESS)
				dev_addr = value[6:0];
		endfunction

		function bit in_transfer();
			return step != SEQ_IDLE;
		endfunction

		function int pending();
			return expected_ticks.size();
		endfunction

		// element of the bus transfer that byte_idx points at
		function elem_e current_elem();
			if (reading) begin
				case (byte_idx)
					0, 3:    return ELEM_START;
					1, 2, 4: return ELEM_SEND;
					5:       return ELEM_RECV;
					default: return ELEM_STOP;
				endcase
			end
			case (byte_idx)
				0:       return ELEM_START;
				1, 2, 3: return ELEM_SEND;
				default: return ELEM_STOP;
			endcase
		endfunction

		function bit [7:0] next_byte();
			case (byte_idx)
				1:       return {dev_addr, 1'b0};
				2:       return reg_latched;
				3:       return data_latched;
				4:       return {dev_addr, 1'b1};
				default: return 8'h00;
			endcase
		endfunction

		function void enter_elem();
			elem_e k;
			k = current_elem();
			phase_cnt = '0;
			case (k)
				ELEM_START: step = SEQ_START_HIGH;
				ELEM_STOP:  step = SEQ_STOP_LOW;
				default: begin
					step = SEQ_BIT_LOW;
					bit_cnt = '0;
					shifter = next_byte();
				end
			endcase
		endfunction

		// {scl, sda} held during the current phase
		function bit [1:0] line_levels();
			bit sda_bit;
			sda_bit = 1'b1;
			case (step)
				SEQ_START_HIGH:                       return 2'b11;
				SEQ_START_SDA_LOW, SEQ_STOP_SCL_HIGH: return 2'b10;
				SEQ_START_SCL_LOW, SEQ_STOP_LOW:      return 2'b00;
				SEQ_BIT_LOW, SEQ_BIT_HIGH, SEQ_BIT_TAIL: begin
					// ninth slot of a sent byte, and every received bit, leave SDA released
					if (current_elem() == ELEM_SEND && bit_cnt < 8)
						sda_bit = shifter[7];
					return {step == SEQ_BIT_HIGH, sda_bit};
				end
				default: return 2'b11;
			endcase
		endfunction

		// returns 1 when the stop completes
		function bit end_phase(bit sda);
			elem_e k;
			bit fin;
			k = current_elem();
			fin = 1'b0;
			phase_cnt = '0;
			case (step)
				SEQ_START_HIGH, SEQ_START_SDA_LOW, SEQ_STOP_LOW, SEQ_STOP_SCL_HIGH:
					step = seq_e'(step + 1);
				SEQ_START_SCL_LOW: begin
					byte_idx++;
					enter_elem();
				end
				SEQ_BIT_LOW: step = SEQ_BIT_HIGH;
				SEQ_BIT_HIGH: begin
					if (k == ELEM_RECV && bit_cnt < 8)
						shifter = {shifter[6:0], sda};
					step = SEQ_BIT_TAIL;
				end
				SEQ_BIT_TAIL: begin
					if (k == ELEM_SEND && bit_cnt < 8)
						shifter = shifter << 1;
					bit_cnt++;
					if (bit_cnt >= 9) begin
						byte_idx++;
						enter_elem();
					end else begin
						step = SEQ_BIT_LOW;
					end
				end
				SEQ_STOP_SDA_HIGH: begin
					if (reading) begin
						last_read = shifter;
						reads_done++;
					end else begin
						writes_done++;
					end
					step = SEQ_IDLE;
					fin = 1'b1;
				end
				default: step = SEQ_IDLE;
			endcase
			return fin;
		endfunction

		function void note_tick(req_t item);
			rsp_t want;
			bit [1:0] lv;
			bit hold;
			int unsigned q;
			want = '0;
			ticks++;
			if (item.kind == KIND_WRITE || item.kind == KIND_READ) begin
				if (step != SEQ_IDLE) begin
					want.rejected = 1'b1;
					refused++;
				end else begin
					reading = (item.kind == KIND_READ);
					reg_latched = item.reg_addr;
					data_latched = item.write_data;
					byte_idx = '0;
					bit_cnt = '0;
					shifter = '0;
					phase_cnt = '0;
					step = SEQ_START_HIGH;
				end
			end
			want.busy_res = (step != SEQ_IDLE);
			lv = line_levels();
			want.scl_drive = lv[1];
			want.sda_drive = lv[0];
			if (want.busy_res) begin
				// clock stretching: high phase does not start counting until SCL reads high
				hold = (step == SEQ_BIT_HIGH) && (phase_cnt == 0) && !item.scl_in;
				if (!hold) begin
					q = (quarter == 0) ? 1 : quarter;
					if (phase_cnt + 1 >= q)
						want.done_res = end_phase(item.sda_in);
					else
						phase_cnt++;
				end
			end
			want.read_value = last_read;
			expected_ticks.push_back(want);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				mismatches++;
				$error("%s: expected %0h, got %0h", name, want, got);
			end
		endfunction

		function void check_tick(rsp_t got);
			rsp_t want;
			if (expected_ticks.size() == 0) begin
				mismatches++;
				$error("response with no tick outstanding: %p", got);
				return;
			end
			want = expected_ticks.pop_front();
			compare_field("scl_drive", want.scl_drive, got.scl_drive);
			compare_field("sda_drive", want.sda_drive, got.sda_drive);
			compare_field("busy_res", want.busy_res, got.busy_res);
			compare_field("done_res", want.done_res, got.done_res);
			compare_field("read_value", want.read_value, got.read_value);
			compare_field("rejected", want.rejected, got.rejected);
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_t                  req       = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	bit steady = 1'b0;
	i2c_tick_scoreboard sb = new();

	i2c_register_access_master dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_tick(rsp);
	end

	// receiver back-pressure: free runs, mostly short stalls, the odd long one
	initial begin : rsp_backpressure
		int unsigned free_run, stall_run;
		forever begin
			free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
			                                       : $urandom_range(1, 12);
			repeat (free_run) @(posedge clk);
			rsp_stall <= 1'b1;
			stall_run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
			                                        : $urandom_range(8, 40);
			repeat (stall_run) @(posedge clk);
			rsp_stall <= 1'b0;
		end
	end

	function automatic int unsigned sender_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// plain bus tick; with noise a stray command or the spare code now and then
	function automatic req_t line_tick(bit noisy, int scl_pct, int sda_mode);
		req_t t;
		int unsigned r;
		t.kind = KIND_TICK;
		t.reg_addr = 8'($urandom);
		t.write_data = 8'($urandom);
		t.scl_in = ($urandom_range(0, 99) < scl_pct);
		case (sda_mode)
			SDA_LOW:  t.sda_in = 1'b0;
			SDA_HIGH: t.sda_in = 1'b1;
			default:  t.sda_in = 1'($urandom);
		endcase
		if (noisy) begin
			r = $urandom_range(0, 99);
			if (r < 2)
				t.kind = KIND_WRITE;
			else if (r < 4)
				t.kind = KIND_READ;
			else if (r < 6)
				t.kind = KIND_NONE;
		end
		return t;
	endfunction

	task automatic push_tick(input req_t item);
		int unsigned gap;
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
		sb.note_tick(item);
		gap = sender_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic run_ticks(input int n, input bit noisy);
		repeat (n) push_tick(line_tick(noisy, 85, SDA_RANDOM));
	endtask

	task automatic run_transfer(input logic [1:0] kind, input logic [7:0] reg_addr,
	                            input logic [7:0] data, input bit noisy,
	                            input int scl_pct, input int sda_mode);
		req_t t;
		t = line_tick(1'b0, scl_pct, sda_mode);
		t.kind = kind;
		t.reg_addr = reg_addr;
		t.write_data = data;
		push_tick(t);
		while (sb.in_transfer())
			push_tick(line_tick(noisy, scl_pct, sda_mode));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.set_register(idx, value);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// only touched with the sequencer idle and every response in
	task automatic configure(input logic [15:0] quarter, input logic [6:0] addr);
		drain();
		write_reg(CFG_QUARTER_PERIOD, quarter);
		write_reg(CFG_DEVICE_ADDRESS, {9'd0, addr});
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		req_t t;
		int unsigned random_base, r, n;
		logic [15:0] quarter;
		logic [1:0] kind;
		int sda_mode, scl_pct;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, idle bus, spare code ignored
		steady = 1'b1;
		run_ticks(6, 1'b0);
		t = line_tick(1'b0, 100, SDA_RANDOM);
		t.kind = KIND_NONE;
		push_tick(t);

		configure(16'd1, 7'd127);
		run_transfer(KIND_WRITE, 8'hFF, 8'h00, 1'b0, 100, SDA_RANDOM);
		run_transfer(KIND_READ, 8'h00, 8'hFF, 1'b0, 100, SDA_HIGH);
		push_tick(t);
		run_transfer(KIND_WRITE, 8'h00, 8'hFF, 1'b0, 100, SDA_LOW);
		run_transfer(KIND_READ, 8'hA5, 8'h5A, 1'b0, 100, SDA_LOW);
		steady = 1'b0;
		// stray commands while busy, plus stretched SCL
		run_transfer(KIND_WRITE, 8'h3C, 8'hC3, 1'b1, 60, SDA_RANDOM);

		// zero quarter period behaves as one tick
		configure(16'd0, 7'd0);
		run_transfer(KIND_READ, 8'h81, 8'h7E, 1'b0, 40, SDA_RANDOM);
		run_transfer(KIND_WRITE, 8'h7E, 8'h81, 1'b1, 85, SDA_RANDOM);

		random_base = sb.ticks;
		while (sb.ticks < random_base + 600) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				quarter = 16'd0;
			else if (r <= 5)
				quarter = 16'd1;
			else if (r <= 7)
				quarter = 16'd2;
			else if (r == 8)
				quarter = 16'd3;
			else
				quarter = 16'($urandom_range(4, 6));
			configure(quarter, 7'($urandom_range(0, 127)));
			steady = ($urandom_range(0, 3) == 0);
			n = $urandom_range(1, 3);
			repeat (n) begin
				run_ticks($urandom_range(0, 4), 1'b0);
				kind = $urandom_range(0, 1) ? KIND_READ : KIND_WRITE;
				r = $urandom_range(0, 99);
				sda_mode = (r < 80) ? SDA_RANDOM : (r < 90) ? SDA_LOW : SDA_HIGH;
				scl_pct = ($urandom_range(0, 99) < 70) ? 90 : $urandom_range(35, 80);
				run_transfer(kind, 8'($urandom), 8'($urandom), $urandom_range(0, 3) != 0,
				             scl_pct, sda_mode);
			end
		end

		// longest quarter period: only the opening of a transfer, with refusals
		configure(16'hFFFF, 7'($urandom_range(0, 127)));
		steady = 1'b0;
		t = line_tick(1'b0, 85, SDA_RANDOM);
		t.kind = KIND_WRITE;
		push_tick(t);
		run_ticks(150, 1'b1);

		drain();
		repeat (20) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.mismatches++;
			$error("%0d responses never arrived", sb.pending());
		end
		$display("%0d bus ticks over %0d register settings: %0d writes and %0d reads done,",
		         sb.ticks, sb.settings, sb.writes_done, sb.reads_done);
		$display("%0d commands refused while busy, with clock stretching and stalls on both sides",
		         sb.refused);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
rtl/i2cram_pkg.sv
rtl/i2cram_cfg_regs.sv
rtl/i2cram_engine.sv
rtl/i2c_register_access_master.sv
bench/tb_i2c_register_access_master.sv
